// ----- hdl/lfu_page_replacement_defines.svh -----
// Assertion macros for the LFU page replacement block.
// The using scope provides clk and rst_n.
`ifndef LFU_PAGE_REPLACEMENT_DEFINES_SVH
`define LFU_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTH
`define LFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LFU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define LFU_ASSERT(lbl, prop, msg)
`define LFU_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- hdl/lfu_pkg.sv -----
package lfu_pkg;

  localparam int CNT_W   = 16;
  localparam int STAMP_W = 32;
  localparam int FLT_W   = 16;
  localparam int CFG_W   = 4;
  localparam int FIDX_W  = 3;
  localparam int EPAGE_W = 8;
  localparam int IN_W    = 8;
  localparam int OUT_W   = 32;
  localparam int USER_W  = 2;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [FLT_W-1:0]   flt_t;
  typedef logic [CFG_W-1:0]   cfg_t;

  localparam cnt_t CNT_MAX = '1;
  localparam flt_t FLT_MAX = '1;
  localparam cfg_t CFG_RST = CFG_W'(8);

  typedef struct packed {
    logic match;
    logic better;
  } cmp_res_t;

endpackage

// ----- hdl/lfu_ram.sv -----
module lfu_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- hdl/lfu_cmp.sv -----
module lfu_cmp #(
  parameter int PAGE_BITS = 8
) (
  input  logic                   entry_valid,
  input  logic [PAGE_BITS-1:0]   ref_page,
  input  logic [PAGE_BITS-1:0]   entry_page,
  input  lfu_pkg::cnt_t          entry_cnt,
  input  lfu_pkg::stamp_t        entry_stamp,
  input  lfu_pkg::cnt_t          best_cnt,
  input  lfu_pkg::stamp_t        best_stamp,
  output lfu_pkg::cmp_res_t      res
);
  import lfu_pkg::*;

  always_comb begin
    res.match  = entry_valid && (entry_page == ref_page);
    res.better = (entry_cnt < best_cnt) ||
                 ((entry_cnt == best_cnt) && (entry_stamp < best_stamp));
  end

endmodule

// ----- hdl/lfu_page_replacement.sv -----
// LFU page replacement with oldest-use tie break. Each input item is one page
// reference; each produces exactly one result item telling whether it hit,
// which frame now holds the page, which page (if any) was evicted, and the
// saturating fault count. Frame pages, use counts and last-use stamps live in
// one RAM that a single compare unit walks one frame per cycle. Each item is
// scanned over the n active frames through the registered RAM read, where n
// is the active frame count set by cfg_wdata (0 acts as 1, above FRAMES acts
// as FRAMES), then written back once the output register is free; the block
// then returns to idle, the only state in which the input is ready. A
// finished result waits in an output register while the next item is
// accepted and scanned. Write configuration only while idle.
`include "lfu_page_replacement_defines.svh"

module lfu_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  lfu_pkg::cfg_t               cfg_wdata,   // frames_in_use
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [lfu_pkg::IN_W-1:0]    in_tdata,    // [7:0] page_number
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lfu_pkg::OUT_W-1:0]   out_tdata,   // [2:0] frame_index,
                                                   // [10:3] evicted_page,
                                                   // [26:11] fault_count
  output logic [lfu_pkg::USER_W-1:0]  out_tuser    // [0] hit, [1] evicted_valid
);
  import lfu_pkg::*;

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW = $clog2(FRAMES + 1);
  localparam int EW = PAGE_BITS + CNT_W + STAMP_W;
  localparam int PAD_W = OUT_W - FLT_W - EPAGE_W - FIDX_W;
  localparam logic [NW-1:0] N_MAX = NW'(FRAMES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WB} state_t;

  state_t                 state_r;
  cfg_t                   cfg_r;
  logic [NW-1:0]          n_r;
  logic [NW-1:0]          n_act;
  logic [PAGE_BITS-1:0]   page_r;
  logic [NW-1:0]          idx_r;
  logic                   pend_r;
  logic [IW-1:0]          eidx_r;
  logic                   found_r;
  logic [IW-1:0]          slot_r;
  cnt_t                   hcnt_r;
  logic                   empty_r;
  logic [IW-1:0]          eslot_r;
  logic [IW-1:0]          vslot_r;
  cnt_t                   vcnt_r;
  stamp_t                 vstamp_r;
  logic [PAGE_BITS-1:0]   vpage_r;
  logic [FRAMES-1:0]      valid_r;
  stamp_t                 stamp_r;
  flt_t                   faults_r;
  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_data_r;
  logic [USER_W-1:0]      out_user_r;

  logic                   issue;
  logic                   wb_go;
  logic                   evict;
  logic [IW-1:0]          sel_slot;
  cnt_t                   cnt_nxt;
  flt_t                   faults_nxt;
  logic [EW-1:0]          rd_data;
  logic [EW-1:0]          wr_data;
  logic [PAGE_BITS-1:0]   e_page;
  cnt_t                   e_cnt;
  stamp_t                 e_stamp;
  logic                   e_valid;
  cmp_res_t               cmp_res;

  always_comb begin
    if (cfg_r == '0) begin
      n_act = NW'(1);
    end else if (32'(cfg_r) > FRAMES) begin
      n_act = N_MAX;
    end else begin
      n_act = NW'(cfg_r);
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign issue = (state_r == S_SCAN) && (idx_r < n_r);
  assign wb_go = (state_r == S_WB) && (!out_valid_r || out_tready);

  assign e_page  = rd_data[EW-1 -: PAGE_BITS];
  assign e_cnt   = rd_data[STAMP_W +: CNT_W];
  assign e_stamp = rd_data[STAMP_W-1:0];
  assign e_valid = valid_r[eidx_r];

  always_comb begin
    evict      = !found_r && !empty_r;
    sel_slot   = found_r ? slot_r : (empty_r ? eslot_r : vslot_r);
    cnt_nxt    = found_r ? ((hcnt_r == CNT_MAX) ? hcnt_r : hcnt_r + CNT_W'(1))
                         : CNT_W'(1);
    faults_nxt = (!found_r && (faults_r != FLT_MAX)) ? faults_r + FLT_W'(1) : faults_r;
    wr_data    = {page_r, cnt_nxt, stamp_r};
  end

  lfu_ram #(
    .WIDTH (EW),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (wb_go),
    .waddr (sel_slot),
    .wdata (wr_data),
    .raddr (idx_r[IW-1:0]),
    .rdata (rd_data)
  );

  lfu_cmp #(
    .PAGE_BITS (PAGE_BITS)
  ) u_cmp (
    .entry_valid (e_valid),
    .ref_page    (page_r),
    .entry_page  (e_page),
    .entry_cnt   (e_cnt),
    .entry_stamp (e_stamp),
    .best_cnt    (vcnt_r),
    .best_stamp  (vstamp_r),
    .res         (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_RST;
      n_r         <= N_MAX;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      empty_r     <= 1'b0;
      valid_r     <= '0;
      stamp_r     <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (out_valid_r && out_tready && !wb_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_SCAN;
            n_r     <= n_act;
            page_r  <= PAGE_BITS'(in_tdata);
            idx_r   <= '0;
            pend_r  <= 1'b0;
            found_r <= 1'b0;
            empty_r <= 1'b0;
          end
        end
        S_SCAN: begin
          pend_r <= issue;
          if (issue) begin
            idx_r  <= idx_r + NW'(1);
            eidx_r <= idx_r[IW-1:0];
          end
          if (pend_r) begin
            if (cmp_res.match && !found_r) begin
              found_r <= 1'b1;
              slot_r  <= eidx_r;
              hcnt_r  <= e_cnt;
            end
            if (!e_valid && !empty_r) begin
              empty_r <= 1'b1;
              eslot_r <= eidx_r;
            end
            if ((eidx_r == '0) || cmp_res.better) begin
              vslot_r  <= eidx_r;
              vcnt_r   <= e_cnt;
              vstamp_r <= e_stamp;
              vpage_r  <= e_page;
            end
            if (idx_r == n_r) begin
              state_r <= S_WB;
            end
          end
        end
        S_WB: begin
          if (wb_go) begin
            state_r           <= S_IDLE;
            valid_r[sel_slot] <= 1'b1;
            stamp_r           <= stamp_r + STAMP_W'(1);
            faults_r          <= faults_nxt;
            out_valid_r       <= 1'b1;
            out_data_r        <= {{PAD_W{1'b0}}, faults_nxt,
                                  (evict ? EPAGE_W'(vpage_r) : EPAGE_W'(0)),
                                  FIDX_W'(sel_slot)};
            out_user_r        <= {evict, found_r};
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `LFU_ASSERT(a_scan_bound, (state_r == S_SCAN) |-> (idx_r <= n_r), "scan index past active frames")
  `LFU_ASSERT(a_slot_active, (state_r == S_WB) |-> (32'(sel_slot) < 32'(n_r)), "slot outside active frames")
  `LFU_ASSERT(a_hit_no_evict, (out_tvalid && out_tuser[0]) |-> !out_tuser[1], "hit reported with eviction")
  `LFU_ASSERT_NEXT(a_faults_mono, 1'b1, faults_r >= $past(faults_r), "fault count decreased")

endmodule

// ----- test/lfu_page_replacement_tb.sv -----
module lfu_page_replacement_tb;
  import lfu_pkg::*;

  localparam int FRAMES      = 8;
  localparam int SOAK_LEN    = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 130;

  typedef enum logic {ROW_PAGE, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] frame;
    logic       ev_valid;
    logic [7:0] ev_page;
    flt_t       faults;
  } access_t;

  typedef struct {
    row_kind_t  kind;
    logic [7:0] val;
    bit         typed;
    access_t    want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_t                  cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic [USER_W-1:0]     out_tuser;

  cfg_t       frames_cfg;
  logic [7:0] pg_tab[FRAMES];
  bit         vld_tab[FRAMES];
  cnt_t       cnt_tab[FRAMES];
  stamp_t     stamp_tab[FRAMES];
  stamp_t     stamp_now;
  flt_t       fault_tot;

  access_t pending_q[$];
  int      fail_cnt   = 0;
  int      checked    = 0;
  int      cfg_writes = 0;
  int      send_pct   = 0;
  int      stall_pct  = 0;
  int      hold_req   = 0;
  int      hold_seen  = 0;
  int      hold_left  = 0;

  lfu_page_replacement dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int active_frames();
    if (frames_cfg == 0) return 1;
    if (frames_cfg > FRAMES) return FRAMES;
    return int'(frames_cfg);
  endfunction

  function automatic access_t lfu_access(logic [7:0] pg);
    access_t r;
    int      n;
    int      i;
    int      slot;
    bit      found;
    bit      empty;
    n = active_frames();
    r = '0;
    slot = 0;
    found = 1'b0;
    empty = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!found && vld_tab[i] && pg_tab[i] == pg) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      if (cnt_tab[slot] != CNT_MAX) cnt_tab[slot]++;
      stamp_tab[slot] = stamp_now;
      stamp_now++;
    end else begin
      for (i = 0; i < n; i++) begin
        if (!empty && !vld_tab[i]) begin
          slot = i;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        slot = 0;
        for (i = 1; i < n; i++) begin
          if (cnt_tab[i] < cnt_tab[slot] ||
              (cnt_tab[i] == cnt_tab[slot] && stamp_tab[i] < stamp_tab[slot]))
            slot = i;
        end
        r.ev_valid = 1'b1;
        r.ev_page  = pg_tab[slot];
      end
      pg_tab[slot]    = pg;
      vld_tab[slot]   = 1'b1;
      cnt_tab[slot]   = cnt_t'(1);
      stamp_tab[slot] = stamp_now;
      stamp_now++;
      if (fault_tot != FLT_MAX) fault_tot++;
    end
    r.hit    = found;
    r.frame  = 3'(slot);
    r.faults = fault_tot;
    return r;
  endfunction

  function automatic row_t pg_row(logic [7:0] v);
    row_t r;
    r.kind  = ROW_PAGE;
    r.val   = v;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic row_t exp_row(logic [7:0] v, logic h, logic [2:0] fr, logic evv,
                                   logic [7:0] evp, flt_t flt);
    row_t r;
    r.kind  = ROW_PAGE;
    r.val   = v;
    r.typed = 1'b1;
    r.want  = '{h, fr, evv, evp, flt};
    return r;
  endfunction

  function automatic row_t cfg_row(logic [7:0] v);
    row_t r;
    r.kind  = ROW_CFG;
    r.val   = v;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    access_t got;
    access_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit      = out_tuser[0];
      got.ev_valid = out_tuser[1];
      got.frame    = out_tdata[2:0];
      got.ev_page  = out_tdata[10:3];
      got.faults   = out_tdata[26:11];
      if (pending_q.size() == 0) begin
        $error("result item with no reference pending: tdata %h tuser %b", out_tdata, out_tuser);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        checked++;
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, got.hit);
          fail_cnt++;
        end
        if (got.frame !== want.frame) begin
          $error("frame_index: expected %0d, got %0d", want.frame, got.frame);
          fail_cnt++;
        end
        if (got.ev_valid !== want.ev_valid) begin
          $error("evicted_valid: expected %0d, got %0d", want.ev_valid, got.ev_valid);
          fail_cnt++;
        end
        if (got.ev_page !== want.ev_page) begin
          $error("evicted_page: expected %0d, got %0d", want.ev_page, got.ev_page);
          fail_cnt++;
        end
        if (got.faults !== want.faults) begin
          $error("fault_count: expected %0d, got %0d", want.faults, got.faults);
          fail_cnt++;
        end
      end
    end
  end

  task automatic set_mode(idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        send_pct = 0;
        stall_pct = 0;
      end
      IDLE_SEND: begin
        send_pct = 46;
        stall_pct = 0;
      end
      IDLE_RECV: begin
        send_pct = 0;
        stall_pct = 46;
      end
      default: begin
        send_pct = 31;
        stall_pct = 31;
      end
    endcase
  endtask

  task automatic send_page(logic [7:0] pg, bit typed, access_t typed_res);
    access_t res;
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pg;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = lfu_access(pg);
    pending_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_frames(cfg_t v);
    drain();
    repeat (16) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    frames_cfg = v;
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic run_random(cfg_t v, idle_mode_t m, bit hold, bit pause);
    logic [7:0] pool[FRAMES+3];
    int         n;
    int         k;
    int         r;
    logic [7:0] pg;
    write_frames(v);
    set_mode(m);
    n = active_frames() + 3;
    for (k = 0; k < n; k++) pool[k] = 8'($urandom_range(255));
    for (k = 0; k < PHASE_ITEMS; k++) begin
      if (hold && k == PHASE_ITEMS / 4) hold_req++;
      if (pause && k == PHASE_ITEMS / 2) drain();
      r = $urandom_range(99);
      if (r < 5) pool[$urandom_range(n - 1)] = 8'($urandom_range(255));
      if (r < 85) pg = pool[$urandom_range(n - 1)];
      else pg = 8'($urandom_range(255));
      send_page(pg, 1'b0, '0);
    end
  endtask

  task automatic soak(logic [7:0] a, logic [7:0] b, int cnt);
    int k;
    for (k = 0; k < cnt; k++) send_page((k % 2 == 0) ? a : b, 1'b0, '0);
  endtask

  initial begin : stimulus
    row_t rows[$];
    int   i;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = CFG_RST;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    frames_cfg = CFG_RST;
    for (i = 0; i < FRAMES; i++) begin
      pg_tab[i]    = '0;
      vld_tab[i]   = 1'b0;
      cnt_tab[i]   = '0;
      stamp_tab[i] = '0;
    end
    stamp_now = '0;
    fault_tot = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back(exp_row(8'h00, 1'b0, 3'd0, 1'b0, 8'h00, 16'd1));
    rows.push_back(exp_row(8'hFF, 1'b0, 3'd1, 1'b0, 8'h00, 16'd2));
    rows.push_back(exp_row(8'h00, 1'b1, 3'd0, 1'b0, 8'h00, 16'd2));
    rows.push_back(exp_row(8'hFF, 1'b1, 3'd1, 1'b0, 8'h00, 16'd2));
    rows.push_back(exp_row(8'h01, 1'b0, 3'd2, 1'b0, 8'h00, 16'd3));
    rows.push_back(exp_row(8'h02, 1'b0, 3'd3, 1'b0, 8'h00, 16'd4));
    rows.push_back(exp_row(8'h03, 1'b0, 3'd4, 1'b0, 8'h00, 16'd5));
    rows.push_back(exp_row(8'h04, 1'b0, 3'd5, 1'b0, 8'h00, 16'd6));
    rows.push_back(exp_row(8'h05, 1'b0, 3'd6, 1'b0, 8'h00, 16'd7));
    rows.push_back(exp_row(8'h06, 1'b0, 3'd7, 1'b0, 8'h00, 16'd8));
    rows.push_back(exp_row(8'h80, 1'b0, 3'd2, 1'b1, 8'h01, 16'd9));
    rows.push_back(exp_row(8'hAA, 1'b0, 3'd3, 1'b1, 8'h02, 16'd10));
    rows.push_back(pg_row(8'h55));
    rows.push_back(cfg_row(8'd2));
    rows.push_back(pg_row(8'h04));
    rows.push_back(pg_row(8'hFF));
    rows.push_back(cfg_row(8'd0));
    rows.push_back(pg_row(8'hFF));
    rows.push_back(pg_row(8'hFF));
    rows.push_back(cfg_row(8'd15));
    rows.push_back(pg_row(8'h04));
    rows.push_back(pg_row(8'hFF));
    rows.push_back(pg_row(8'h7F));
    rows.push_back(pg_row(8'h80));
    rows.push_back(cfg_row(8'd8));

    set_mode(IDLE_NONE);
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_frames(rows[i].val[CFG_W-1:0]);
      else send_page(rows[i].val, rows[i].typed, rows[i].want);
    end

    run_random(4'd8,  IDLE_NONE, 1'b1, 1'b0);
    run_random(4'd8,  IDLE_SEND, 1'b0, 1'b1);
    run_random(4'd1,  IDLE_RECV, 1'b0, 1'b0);
    run_random(4'd0,  IDLE_BOTH, 1'b0, 1'b0);
    run_random(4'd3,  IDLE_NONE, 1'b0, 1'b1);
    run_random(4'd15, IDLE_SEND, 1'b0, 1'b0);
    run_random(4'd5,  IDLE_RECV, 1'b1, 1'b0);
    run_random(4'd8,  IDLE_BOTH, 1'b0, 1'b0);
    run_random(4'd2,  IDLE_SEND, 1'b0, 1'b0);
    run_random(4'd12, IDLE_RECV, 1'b0, 1'b1);
    run_random(4'd6,  IDLE_BOTH, 1'b1, 1'b0);
    run_random(4'd4,  IDLE_NONE, 1'b0, 1'b0);

    write_frames(4'd1);
    set_mode(IDLE_NONE);
    soak(8'h10, 8'h11, SOAK_LEN);
    write_frames(4'd2);
    soak(8'h20, 8'h20, SOAK_LEN);
    soak(8'h21, 8'h21, 12);
    soak(8'h22, 8'h22, 1);
    soak(8'h20, 8'h20, 1);

    drain();
    repeat (20) @(posedge clk);
    $display("Checked %0d result items over %0d frame-count writes (0, 1, 8 and 15 included),",
             checked, cfg_writes);
    $display("with output hold-offs, drained pauses and idle patterns on both sides.");
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
